// ===== rtl/sha1_pkg.sv =====
package sha1_pkg;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic       start;
        logic [3:0] slot;
        logic       wr;
        t_word      wdata;
    } t_win_ctl;

    function automatic t_word rotl(input t_word v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

endpackage

// ===== rtl/sha1_hash_core.sv =====
// sha1_hash_core: sha-1 digest of a byte stream
//
// input channel: i_valid/o_stall with i_data_byte, i_has_byte, i_last_byte.
// a transaction with i_has_byte carries one message byte; i_last_byte closes
// the message (with or without a byte) and starts padding and length append.
// output channel: o_valid/i_stall with o_digest_word, o_word_index,
// o_last_word; five transactions, word 0 first, word 4 flagged last.
// a byte is taken in any cycle with o_stall low; the 64th byte of a block starts a
// compression with the input stalled: block memory reads that fill the schedule
// window, 80 rounds at one per cycle, then one chain update.
// a last transaction adds a pad sweep from the fill position to the end of the
// block and one compression; a fill of 56 or more needs a second, full sweep
// and compression before the first digest word is given.
// o_stall is high while a block is padded or compressed and until word 4 is taken.
// if i_stall holds, the current digest word holds on the port.
// a synchronous active-low reset loads the initial chaining words and
// clears counts; afterward the next message starts from scratch.
module sha1_hash_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    typedef enum logic [5:0] {
        S_FILL  = 6'b000001,
        S_PAD   = 6'b000010,
        S_LOAD  = 6'b000100,
        S_ROUND = 6'b001000,
        S_ADD   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [7:0]  blk [64];
    logic [7:0]  r_blk_rd;
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_bits, n_bits;
    logic        r_final, n_final;
    logic        r_len_done, n_len_done;
    logic        r_final_pad_done, n_final_pad_done;
    logic [6:0]  r_cnt, n_cnt;
    logic [2:0]  r_oidx, n_oidx;
    logic [23:0] r_acc, n_acc;
    sha1_pkg::t_word r_h [5];
    sha1_pkg::t_word r_a, r_b, r_c, r_d, r_e;

    logic       blk_we;
    logic [5:0] blk_wa;
    logic [7:0] blk_wd;
    logic [5:0] blk_ra;
    sha1_pkg::t_win_ctl win;
    sha1_pkg::t_word win_tap0, win_tap2, win_tap8, win_tap13;

    logic [6:0] rnd;
    logic [3:0] slot;
    sha1_pkg::t_word wnew, wcur, f, k, t;
    assign rnd  = r_cnt;
    assign slot = rnd[3:0];

    sha1_win_mem u_win (
        .i_clk    (i_clk),
        .i_wr_addr(win.slot),
        .i_wr_en  (win.wr),
        .i_wr_data(win.wdata),
        .i_slot   (slot),
        .o_tap0   (win_tap0),
        .o_tap2   (win_tap2),
        .o_tap8   (win_tap8),
        .o_tap13  (win_tap13)
    );

    logic in_acc;
    assign o_stall = (r_state != S_FILL);
    assign in_acc  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (blk_we) begin
            blk[blk_wa] <= blk_wd;
        end
        r_blk_rd <= blk[blk_ra];
    end

    always_comb begin
        wnew = sha1_pkg::rotl(win_tap13 ^ win_tap8 ^ win_tap2 ^ win_tap0, 1);
        wcur = (rnd >= 7'd16) ? wnew : win_tap0;
        priority if (rnd < 7'd20) begin
            f = (r_b & r_c) | (~r_b & r_d); k = sha1_pkg::K0;
        end else if (rnd < 7'd40) begin
            f = r_b ^ r_c ^ r_d; k = sha1_pkg::K1;
        end else if (rnd < 7'd60) begin
            f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d); k = sha1_pkg::K2;
        end else begin
            f = r_b ^ r_c ^ r_d; k = sha1_pkg::K3;
        end
        t = sha1_pkg::rotl(r_a, 5) + f + r_e + k + wcur;
    end

    // length or zero byte for the current position during pad sweep
    logic [7:0] pad_byte;
    logic [2:0] lsel;
    assign lsel = r_cnt[2:0];
    always_comb begin
        pad_byte = 8'h00;
        if (r_cnt[5:0] >= 6'd56 && r_len_done) begin
            pad_byte = r_bits[8'd63 - {2'b00, lsel, 3'b000} -: 8];
        end
    end

    always_comb begin
        n_state = r_state; n_fill = r_fill; n_bits = r_bits; n_final = r_final;
        n_len_done = r_len_done; n_cnt = r_cnt; n_oidx = r_oidx; n_acc = r_acc;
        blk_we = 1'b0; blk_wa = r_fill; blk_wd = i_data_byte; blk_ra = 6'd0;
        win.start = 1'b0; win.slot = r_cnt[5:2]; win.wr = 1'b0; win.wdata = '0;
        unique case (r_state)
            S_FILL: begin
                if (in_acc) begin
                    if (i_has_byte) begin
                        blk_we = 1'b1;
                        n_bits = r_bits + 64'd8;
                        n_fill = r_fill + 6'd1;
                        n_final = i_last_byte;
                        if (r_fill == 6'd63) begin
                            n_state = S_LOAD; n_cnt = '0; n_len_done = 1'b0;
                        end else if (i_last_byte) begin
                            n_state = S_PAD; n_cnt = {1'b0, r_fill + 6'd1};
                            n_len_done = (r_fill + 6'd1) < 6'd56;
                        end
                    end else if (i_last_byte) begin
                        n_final = 1'b1;
                        n_state = S_PAD; n_cnt = {1'b0, r_fill};
                        n_len_done = r_fill < 6'd56;
                    end
                end
            end
            S_PAD: begin
                // sweep from fill position to end of block
                blk_we = 1'b1; blk_wa = r_cnt[5:0];
                blk_wd = (r_cnt[5:0] == r_fill && !r_final_pad_done) ? sha1_pkg::PAD_BYTE
                       : pad_byte;
                n_cnt = r_cnt + 7'd1;
                if (r_cnt[5:0] == 6'd63) begin
                    n_state = S_LOAD; n_cnt = '0;
                end
            end
            S_LOAD: begin
                // read bytes sequentially, pack words, write window memory
                blk_ra = r_cnt[5:0];
                if (r_cnt != 7'd0) begin
                    n_acc = {r_acc[15:0], r_blk_rd};
                    if (r_cnt[1:0] == 2'd0) begin
                        win.wr = 1'b1; win.slot = r_cnt[5:2] - 4'd1;
                        win.wdata = {r_acc, r_blk_rd};
                    end
                end
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd64) begin
                    n_state = S_ROUND; n_cnt = '0; win.start = 1'b1;
                end
            end
            S_ROUND: begin
                win.slot = slot; win.wr = 1'b1; win.wdata = wcur;
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd79) begin
                    n_state = S_ADD; n_cnt = '0;
                end
            end
            S_ADD: begin
                if (!r_final) begin
                    n_state = S_FILL; n_fill = '0;
                end else if (!r_len_done) begin
                    n_state = S_PAD; n_cnt = '0; n_len_done = 1'b1; n_fill = 6'd0;
                end else begin
                    n_state = S_OUT; n_oidx = '0;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == 3'd4) begin
                        n_state = S_FILL; n_fill = '0; n_bits = '0; n_final = 1'b0;
                    end
                end
            end
            default: n_state = S_FILL;
        endcase
    end

    // marks that the 0x80 pad byte has already gone into an earlier block
    always_comb begin
        n_final_pad_done = r_final_pad_done;
        if (r_state == S_PAD && r_cnt[5:0] == 6'd63) begin
            n_final_pad_done = 1'b1;
        end
        if (r_state == S_FILL) begin
            n_final_pad_done = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL; r_fill <= '0; r_bits <= '0; r_final <= 1'b0;
            r_len_done <= 1'b0; r_cnt <= '0; r_oidx <= '0; r_final_pad_done <= 1'b0;
            r_h[0] <= sha1_pkg::H0; r_h[1] <= sha1_pkg::H1; r_h[2] <= sha1_pkg::H2;
            r_h[3] <= sha1_pkg::H3; r_h[4] <= sha1_pkg::H4;
        end else begin
            r_state <= n_state; r_fill <= n_fill; r_bits <= n_bits;
            r_final <= n_final; r_len_done <= n_len_done; r_cnt <= n_cnt;
            r_oidx <= n_oidx; r_final_pad_done <= n_final_pad_done;
            if (r_state == S_ADD) begin
                r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c; r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end
            if (r_state == S_OUT && !i_stall && r_oidx == 3'd4) begin
                r_h[0] <= sha1_pkg::H0; r_h[1] <= sha1_pkg::H1;
                r_h[2] <= sha1_pkg::H2; r_h[3] <= sha1_pkg::H3;
                r_h[4] <= sha1_pkg::H4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (r_state == S_ROUND) begin
            r_e <= r_d; r_d <= r_c; r_c <= sha1_pkg::rotl(r_b, 30);
            r_b <= r_a; r_a <= t;
        end else if (win.start) begin
            r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3];
            r_e <= r_h[4];
        end
    end

    assign o_valid       = (r_state == S_OUT);
    assign o_digest_word = r_h[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 3'd4);
endmodule

// ===== rtl/sha1_win_mem.sv =====
module sha1_win_mem (
    input  logic               i_clk,
    input  logic [3:0]         i_wr_addr,
    input  logic               i_wr_en,
    input  sha1_pkg::t_word    i_wr_data,
    input  logic [3:0]         i_slot,
    output sha1_pkg::t_word    o_tap0,
    output sha1_pkg::t_word    o_tap2,
    output sha1_pkg::t_word    o_tap8,
    output sha1_pkg::t_word    o_tap13
);
    sha1_pkg::t_word mem [16];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // schedule taps relative to the current round slot
    assign o_tap0  = mem[i_slot];
    assign o_tap2  = mem[i_slot + 4'd2];
    assign o_tap8  = mem[i_slot + 4'd8];
    assign o_tap13 = mem[i_slot + 4'd13];
endmodule
